@@ sv/ordered_queue_with_value_edit_macros.svh @@
// assertion macros for the ordered queue block
`ifndef ORDERED_QUEUE_WITH_VALUE_EDIT_MACROS_SVH
`define ORDERED_QUEUE_WITH_VALUE_EDIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked on every rising clock edge out of reset
`define OQVE_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on every rising clock edge out of reset
`define OQVE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define OQVE_ASSERT_IMP(lbl, ante, cons, msg)
`define OQVE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ sv/oqve_pkg.sv @@
// shared types and constants for the ordered queue block
package oqve_pkg;

   localparam int DEPTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int VAL_W = 32;

   typedef enum logic [1:0] {
      FUNC_ENQ = 2'd0,
      FUNC_DEQ = 2'd1,
      FUNC_DEL = 2'd2,
      FUNC_INS = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // committed operation, broadcast to every cell
   typedef struct packed {
      logic enq;
      logic deq;
      logic del;
      logic ins;
   } cmd_type;

endpackage

@@ sv/oqve_cell.sv @@
// one queue cell: holds an entry, matches the key, shifts with its neighbors
module oqve_cell
   import oqve_pkg::*;
(
   input  logic             clock,
   input  cmd_type          cmd,
   input  logic [VAL_W-1:0] key,
   input  logic [VAL_W-1:0] new_value,
   input  logic             first,
   input  logic             valid,
   input  logic             left_valid,
   input  logic [VAL_W-1:0] left_value,
   input  logic [VAL_W-1:0] right_value,
   input  logic             match_above_in,
   input  logic             sel_seen_in,
   input  logic             front_match,
   output logic [VAL_W-1:0] value,
   output logic             hit,
   output logic             match_out,
   output logic             sel_seen_out
);

   logic [VAL_W-1:0] value_ff;
   logic [VAL_W-1:0] value_in;
   logic             sel;
   logic             at_or_after;
   logic             tail;

   // local key match and the chains toward the neighbors
   assign hit          = valid && (value_ff == key);
   assign match_out    = hit || match_above_in;
   assign sel          = front_match ? first : (hit && !match_above_in);
   assign at_or_after  = sel_seen_in || sel;
   assign sel_seen_out = at_or_after;
   assign tail         = !valid && left_valid;

   // next entry value
   always_comb begin
      priority if (cmd.enq && tail) begin
         value_in = key;
      end else if (cmd.deq) begin
         value_in = right_value;
      end else if (cmd.del && at_or_after) begin
         value_in = right_value;
      end else if (cmd.ins && sel) begin
         value_in = new_value;
      end else if (cmd.ins && at_or_after) begin
         value_in = left_value;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

@@ sv/ordered_queue_with_value_edit.sv @@
// top level of the ordered queue with value edit
//
//   channel   ports                                   handshake
//   request   req_func, req_value, req_new_value      start & !busy
//   response  rsp_status, rsp_entry_count,            rsp_strobe, one cycle
//             rsp_front_valid, rsp_front_value
//
// one item per cycle: the row of cells matches the key in every cell at once
// and all cells shift in the same cycle, so busy stays low.
// the result appears the cycle after the item is taken and lasts one cycle.
// reset empties the queue (count to zero); entry storage keeps no reset.
// the receiver cannot stall, so nothing is held back.
`include "ordered_queue_with_value_edit_macros.svh"

module ordered_queue_with_value_edit
   import oqve_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [1:0]       req_func,
   input  logic [VAL_W-1:0] req_value,
   input  logic [VAL_W-1:0] req_new_value,
   output logic             rsp_strobe,
   output logic [1:0]       rsp_status,
   output logic [CNT_W-1:0] rsp_entry_count,
   output logic             rsp_front_valid,
   output logic [VAL_W-1:0] rsp_front_value
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             strobe_ff;
   logic             strobe_in;
   status_type       status_ff;
   status_type       status_in;

   logic [VAL_W-1:0] cell_value [DEPTH];
   logic [DEPTH-1:0] cell_valid;
   logic [DEPTH-1:0] cell_hit;
   logic [DEPTH:0]   match_chain;
   logic [DEPTH:0]   sel_chain;

   logic             accept;
   logic             full;
   logic             empty;
   logic             found;
   cmd_type          cmd;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (count_ff == CNT_W'(DEPTH));
   assign empty  = (count_ff == '0);
   assign found  = match_chain[0];

   assign match_chain[DEPTH] = 1'b0;
   assign sel_chain[0]       = 1'b0;

   // row of cells, index 0 is the front
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic             left_valid;
      logic [VAL_W-1:0] left_value;
      logic [VAL_W-1:0] right_value;

      assign cell_valid[i] = (count_ff > CNT_W'(i));

      if (i == 0) begin : g_front
         assign left_valid = 1'b1;
         assign left_value = '0;
      end else begin : g_inner
         assign left_valid = cell_valid[i-1];
         assign left_value = cell_value[i-1];
      end

      if (i == DEPTH - 1) begin : g_rear
         assign right_value = '0;
      end else begin : g_mid
         assign right_value = cell_value[i+1];
      end

      oqve_cell u_cell (
         .clock          (clock),
         .cmd            (cmd),
         .key            (req_value),
         .new_value      (req_new_value),
         .first          (i == 0),
         .valid          (cell_valid[i]),
         .left_valid     (left_valid),
         .left_value     (left_value),
         .right_value    (right_value),
         .match_above_in (match_chain[i+1]),
         .sel_seen_in    (sel_chain[i]),
         .front_match    (cell_hit[0]),
         .value          (cell_value[i]),
         .hit            (cell_hit[i]),
         .match_out      (match_chain[i]),
         .sel_seen_out   (sel_chain[i+1])
      );
   end

   // decode the item into a committed command and its status
   always_comb begin
      cmd       = '0;
      status_in = ST_OK;
      unique case (func_type'(req_func))
         FUNC_ENQ: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               cmd.enq = accept;
            end
         end
         FUNC_DEQ: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               cmd.deq = accept;
            end
         end
         FUNC_DEL: begin
            priority if (empty) begin
               status_in = ST_EMPTY;
            end else if (!found) begin
               status_in = ST_NOT_FOUND;
            end else begin
               cmd.del = accept;
            end
         end
         FUNC_INS: begin
            priority if (empty) begin
               status_in = ST_EMPTY;
            end else if (!found) begin
               status_in = ST_NOT_FOUND;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               cmd.ins = accept;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   // occupancy update
   always_comb begin
      priority if (cmd.enq || cmd.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.deq || cmd.del) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   assign strobe_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
   end

   // response reads the state left by the item
   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = count_ff;
   assign rsp_front_valid = !empty;
   assign rsp_front_value = empty ? '0 : cell_value[0];

   `OQVE_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= CNT_W'(DEPTH), "count above depth")
   `OQVE_ASSERT_NEXT(a_accept_strobe, accept, rsp_strobe, "accepted item gave no result")
   `OQVE_ASSERT_NEXT(a_enq_grows, cmd.enq, count_ff == $past(count_ff) + CNT_W'(1), "enqueue lost")
   `OQVE_ASSERT_NEXT(a_deq_ok, cmd.deq, rsp_status == ST_OK, "dequeue on a non-empty queue not ok")

endmodule
